@@ src/fpvm_pkg.sv @@
// fpvm_pkg: operation codes, status codes and fixed constants of the
// fixed-point stack machine execute unit; no dependencies
package fpvm_pkg;

  localparam logic [5:0] OP_PUSH_I   = 6'd0;
  localparam logic [5:0] OP_PUSH_R   = 6'd1;
  localparam logic [5:0] OP_RD_VAR   = 6'd2;
  localparam logic [5:0] OP_WR_VAR   = 6'd3;
  localparam logic [5:0] OP_RD_GVAR  = 6'd4;
  localparam logic [5:0] OP_WR_GVAR  = 6'd5;
  localparam logic [5:0] OP_MUL      = 6'd6;
  localparam logic [5:0] OP_DIV      = 6'd7;
  localparam logic [5:0] OP_ADD      = 6'd8;
  localparam logic [5:0] OP_SUB      = 6'd9;
  localparam logic [5:0] OP_JMP      = 6'd10;
  localparam logic [5:0] OP_JNZ      = 6'd11;
  localparam logic [5:0] OP_JZ       = 6'd12;
  localparam logic [5:0] OP_ENTER    = 6'd13;
  localparam logic [5:0] OP_LEAVE    = 6'd14;
  localparam logic [5:0] OP_RETURN   = 6'd15;
  localparam logic [5:0] OP_CALL     = 6'd16;
  localparam logic [5:0] OP_POP      = 6'd17;
  localparam logic [5:0] OP_TEQ      = 6'd18;
  localparam logic [5:0] OP_TNEQ     = 6'd19;
  localparam logic [5:0] OP_TL       = 6'd20;
  localparam logic [5:0] OP_TG       = 6'd21;
  localparam logic [5:0] OP_TLEQ     = 6'd22;
  localparam logic [5:0] OP_TGEQ     = 6'd23;
  localparam logic [5:0] OP_DUP      = 6'd24;
  localparam logic [5:0] OP_AINIT    = 6'd25;
  localparam logic [5:0] OP_AINIT_G  = 6'd26;
  localparam logic [5:0] OP_RD_ARR   = 6'd27;
  localparam logic [5:0] OP_RD_GARR  = 6'd28;
  localparam logic [5:0] OP_WR_ARR   = 6'd29;
  localparam logic [5:0] OP_WR_GARR  = 6'd30;
  localparam logic [5:0] OP_ENTRY    = 6'd31;

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_RET  = 3'd1;
  localparam logic [2:0] ST_OVF  = 3'd2;
  localparam logic [2:0] ST_UNF  = 3'd3;
  localparam logic [2:0] ST_BND  = 3'd4;
  localparam logic [2:0] ST_UNK  = 3'd5;
  localparam logic [2:0] ST_DIV0 = 3'd6;

  localparam logic [31:0] ONE_FX   = 32'h0001_0000;
  localparam logic [31:0] RET_MARK = 32'hFFFF_FFFF;

  localparam int DIV_STEPS = 48;

endpackage

@@ src/fpvm_mem.sv @@
// fpvm_mem: single-port word store, registered read
// no dependencies
module fpvm_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/fpvm_div.sv @@
// fpvm_div: iterative signed 16.16 divide, one quotient bit per cycle
// depends on fpvm_pkg
module fpvm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  output logic        done,
  output logic [31:0] quo
);

  localparam int CW = $clog2(fpvm_pkg::DIV_STEPS);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [47:0]   qd_r, qd_nxt;
  logic [31:0]   dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [32:0]   rsh;
  logic          ge;
  logic [31:0]   dvd_mag, dvs_mag;

  assign dvd_mag = dvd[31] ? (~dvd + 32'd1) : dvd;
  assign dvs_mag = dvs[31] ? (~dvs + 32'd1) : dvs;
  assign rsh = {rem_r, qd_r[47]};
  assign ge  = rsh >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    qd_nxt   = qd_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      qd_nxt  = {dvd_mag, 16'h0000};
      dvs_nxt = dvs_mag;
      neg_nxt = dvd[31] ^ dvs[31];
    end else if (run_r) begin
      rem_nxt = ge ? 32'(rsh - {1'b0, dvs_r}) : rsh[31:0];
      qd_nxt  = {qd_r[46:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(fpvm_pkg::DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? (~qd_r[31:0] + 32'd1) : qd_r[31:0];

endmodule

@@ src/fixed_point_stack_vm_execute_top.sv @@
// fixed_point_stack_vm_execute_top: sequencer of the 16.16 stack machine
// depends on fpvm_pkg, fpvm_mem, fpvm_div
//
// Usage: present a decoded instruction (in_cmd, in_arg, in_next_addr) with
// start; it is taken at a clock edge where start is high and busy is low.
// Exactly one result word follows: out_strobe is high for one cycle with
// out_next_pc, out_status and out_value, and the receiver must take it then.
// The state sits in one single-port word store; the sequencer pops, reads,
// writes and pushes one word at a time. An instruction runs through its
// pops, its store reads, its execute steps and its pushes, then the result
// cycle; a multiply or an array store needs an extra execute step, a divide
// waits for the divider, and an array initialization writes two header words
// and then one word per element. Call entry skips the pop check; an ignored
// item under a sticky error goes straight to the result cycle.
// busy stays high until the result cycle has ended; one word is in flight.
// After reset the store is cleared one word per cycle, all STACK_WORDS words
// with busy high; configuration writes are taken during that sweep.
// cfg_we with cfg_wdata sets the global word count, which also loads the
// stack pointer and frame base and clears the sticky error.
module fixed_point_stack_vm_execute_top #(
  parameter int STACK_WORDS    = 1024,
  parameter int PROG_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_cmd,
  input  logic [31:0] in_arg,
  input  logic [15:0] in_next_addr,
  output logic        out_strobe,
  output logic [15:0] out_next_pc,
  output logic [2:0]  out_status,
  output logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int AW = $clog2(STACK_WORDS);
  localparam int SW = $clog2(STACK_WORDS + 1);
  localparam int PA = PROG_ADDR_BITS;
  localparam logic signed [33:0] SWL = 34'(STACK_WORDS);
  localparam logic signed [33:0] LIM = 34'(STACK_WORDS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  function automatic logic [2:0] addr_chk(input logic signed [33:0] a,
                                          input logic signed [33:0] lim);
    logic [2:0] c;
    c = fpvm_pkg::ST_RUN;
    if (a < 0) begin
      c = fpvm_pkg::ST_UNF;
    end else if (a > lim) begin
      c = fpvm_pkg::ST_OVF;
    end
    return c;
  endfunction

  function automatic logic [1:0] pop_count(input logic [5:0] c);
    logic [1:0] n;
    case (c)
      fpvm_pkg::OP_TEQ, fpvm_pkg::OP_TNEQ, fpvm_pkg::OP_TL, fpvm_pkg::OP_TG,
      fpvm_pkg::OP_TLEQ, fpvm_pkg::OP_TGEQ, fpvm_pkg::OP_WR_ARR,
      fpvm_pkg::OP_WR_GARR, fpvm_pkg::OP_MUL, fpvm_pkg::OP_DIV,
      fpvm_pkg::OP_ADD, fpvm_pkg::OP_SUB: n = 2'd2;
      fpvm_pkg::OP_AINIT, fpvm_pkg::OP_AINIT_G, fpvm_pkg::OP_RD_ARR,
      fpvm_pkg::OP_RD_GARR, fpvm_pkg::OP_WR_VAR, fpvm_pkg::OP_WR_GVAR,
      fpvm_pkg::OP_JNZ, fpvm_pkg::OP_JZ, fpvm_pkg::OP_LEAVE,
      fpvm_pkg::OP_POP, fpvm_pkg::OP_DUP: n = 2'd1;
      fpvm_pkg::OP_RETURN: n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  logic [3:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [SW-1:0]      sp_r, sp_nxt;
  logic [SW-1:0]      fb_r, fb_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [5:0]         op_r, op_nxt;
  logic signed [31:0] arg_r, arg_nxt;
  logic [PA-1:0]      npc_r, npc_nxt;
  logic [2:0]         status_r, status_nxt;
  logic [31:0]        value_r, value_nxt;
  logic [31:0]        pv_r [3];
  logic [31:0]        pv_nxt [3];
  logic [1:0]         pcnt_r, pcnt_nxt;
  logic [1:0]         pneed_r, pneed_nxt;
  logic [1:0]         pleft_r, pleft_nxt;
  logic [31:0]        pq0_r, pq0_nxt;
  logic [31:0]        pq1_r, pq1_nxt;
  logic signed [33:0] x_r, x_nxt;
  logic [31:0]        d_r, d_nxt;
  logic [31:0]        rd_r, rd_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        mem_wdata;
  logic [31:0]        mem_rdata;
  logic               div_go;
  logic               div_done;
  logic [31:0]        div_q;

  logic signed [33:0] arg34, fb34, sp34, bx, n_enter, n_leave, nb34, ysx, elem;
  logic signed [15:0] ysh;
  logic [31:0]        ypick;
  logic               is_local, is_wr_arr, cmp_hit;
  logic [2:0]         chk_a, chk_b;
  logic [SW-1:0]      cfg_sat;

  assign arg34    = 34'(arg_r);
  assign fb34     = 34'(fb_r);
  assign sp34     = 34'(sp_r);
  assign is_local = (op_r == fpvm_pkg::OP_RD_VAR) || (op_r == fpvm_pkg::OP_WR_VAR) ||
                    (op_r == fpvm_pkg::OP_AINIT) || (op_r == fpvm_pkg::OP_RD_ARR) ||
                    (op_r == fpvm_pkg::OP_WR_ARR);
  assign is_wr_arr = (op_r == fpvm_pkg::OP_WR_ARR) || (op_r == fpvm_pkg::OP_WR_GARR);
  assign bx       = is_local ? (fb34 + arg34) : arg34;
  assign n_enter  = sp34 + arg34;
  assign n_leave  = sp34 - arg34;
  assign nb34     = 34'($signed(pv_r[2]));
  assign ypick    = is_wr_arr ? pv_r[1] : pv_r[0];
  assign ysh      = 16'($signed(ypick) >>> 16);
  assign ysx      = 34'(ysh);
  assign elem     = 34'($signed(d_r)) + 34'sd1 + ysx;
  assign cfg_sat  = (34'(cfg_wdata) > SWL) ? SW'(STACK_WORDS) : SW'(cfg_wdata);

  always_comb begin
    case (op_r)
      fpvm_pkg::OP_TEQ:  cmp_hit = $signed(pv_r[1]) == $signed(pv_r[0]);
      fpvm_pkg::OP_TNEQ: cmp_hit = $signed(pv_r[1]) != $signed(pv_r[0]);
      fpvm_pkg::OP_TL:   cmp_hit = $signed(pv_r[1]) <  $signed(pv_r[0]);
      fpvm_pkg::OP_TG:   cmp_hit = $signed(pv_r[1]) >  $signed(pv_r[0]);
      fpvm_pkg::OP_TLEQ: cmp_hit = $signed(pv_r[1]) <= $signed(pv_r[0]);
      default:           cmp_hit = $signed(pv_r[1]) >= $signed(pv_r[0]);
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    sp_nxt     = sp_r;
    fb_nxt     = fb_r;
    err_nxt    = err_r;
    ph_nxt     = ph_r;
    op_nxt     = op_r;
    arg_nxt    = arg_r;
    npc_nxt    = npc_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    pv_nxt     = pv_r;
    pcnt_nxt   = pcnt_r;
    pneed_nxt  = pneed_r;
    pleft_nxt  = pleft_r;
    pq0_nxt    = pq0_r;
    pq1_nxt    = pq1_r;
    x_nxt      = x_r;
    d_nxt      = d_r;
    rd_nxt     = rd_r;
    cnt_nxt    = cnt_r;
    prod_nxt   = prod_r;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    div_go     = 1'b0;
    chk_a      = addr_chk(x_r, LIM);
    chk_b      = fpvm_pkg::ST_RUN;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(STACK_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_cmd;
          arg_nxt    = in_arg;
          npc_nxt    = PA'({16'h0000, in_next_addr});
          status_nxt = fpvm_pkg::ST_RUN;
          value_nxt  = '0;
          ph_nxt     = '0;
          pcnt_nxt   = '0;
          pleft_nxt  = '0;
          pneed_nxt  = pop_count(in_cmd);
          if (in_cmd == fpvm_pkg::OP_ENTRY) begin
            err_nxt   = fpvm_pkg::ST_RUN;
            state_nxt = S_EXEC;
          end else if (err_r != fpvm_pkg::ST_RUN) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        if (pcnt_r == pneed_r) begin
          state_nxt = S_EXEC;
        end else if (sp_r == '0) begin
          err_nxt   = fpvm_pkg::ST_UNF;
          state_nxt = S_DONE;
        end else begin
          mem_addr  = AW'(sp_r - SW'(1));
          sp_nxt    = sp_r - SW'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        pv_nxt[pcnt_r] = mem_rdata;
        pcnt_nxt       = pcnt_r + 2'd1;
        state_nxt      = S_POP;
      end
      S_RD: begin
        if (chk_a != fpvm_pkg::ST_RUN) begin
          err_nxt   = chk_a;
          state_nxt = S_DONE;
        end else begin
          mem_addr  = AW'(x_r);
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        rd_nxt    = mem_rdata;
        ph_nxt    = ph_r + 2'd1;
        state_nxt = S_EXEC;
      end
      S_PUSH: begin
        if (pleft_r == '0) begin
          if (op_r == fpvm_pkg::OP_CALL || op_r == fpvm_pkg::OP_ENTRY) begin
            fb_nxt = sp_r;
          end
          state_nxt = S_DONE;
        end else if (sp_r == SW'(STACK_WORDS)) begin
          err_nxt   = fpvm_pkg::ST_OVF;
          state_nxt = S_DONE;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = AW'(sp_r);
          mem_wdata = pq0_r;
          sp_nxt    = sp_r + SW'(1);
          pq0_nxt   = pq1_r;
          pleft_nxt = pleft_r - 2'd1;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          fpvm_pkg::OP_PUSH_I: begin
            pq0_nxt   = {arg_r[15:0], 16'h0000};
            pleft_nxt = 2'd1;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_PUSH_R: begin
            pq0_nxt   = arg_r;
            pleft_nxt = 2'd1;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_RD_VAR, fpvm_pkg::OP_RD_GVAR: begin
            if (ph_r == 2'd0) begin
              x_nxt     = bx;
              state_nxt = S_RD;
            end else begin
              pq0_nxt   = rd_r;
              pleft_nxt = 2'd1;
              state_nxt = S_PUSH;
            end
          end
          fpvm_pkg::OP_WR_VAR, fpvm_pkg::OP_WR_GVAR: begin
            chk_b = addr_chk(bx, LIM);
            if (chk_b != fpvm_pkg::ST_RUN) begin
              err_nxt = chk_b;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = AW'(bx);
              mem_wdata = pv_r[0];
            end
          end
          fpvm_pkg::OP_MUL: begin
            if (ph_r == 2'd0) begin
              prod_nxt  = $signed(pv_r[0]) * $signed(pv_r[1]);
              ph_nxt    = 2'd1;
              state_nxt = S_EXEC;
            end else begin
              pq0_nxt   = prod_r[47:16];
              pleft_nxt = 2'd1;
              state_nxt = S_PUSH;
            end
          end
          fpvm_pkg::OP_DIV: begin
            if (ph_r == 2'd0) begin
              if (pv_r[0] == '0) begin
                err_nxt = fpvm_pkg::ST_DIV0;
              end else begin
                div_go    = 1'b1;
                ph_nxt    = 2'd1;
                state_nxt = S_EXEC;
              end
            end else if (div_done) begin
              pq0_nxt   = div_q;
              pleft_nxt = 2'd1;
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_EXEC;
            end
          end
          fpvm_pkg::OP_ADD: begin
            pq0_nxt   = pv_r[1] + pv_r[0];
            pleft_nxt = 2'd1;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_SUB: begin
            pq0_nxt   = pv_r[1] - pv_r[0];
            pleft_nxt = 2'd1;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_JMP: begin
            npc_nxt = PA'(arg_r);
          end
          fpvm_pkg::OP_JNZ: begin
            if (pv_r[0] != '0) begin
              npc_nxt = PA'(arg_r);
            end
          end
          fpvm_pkg::OP_JZ: begin
            if (pv_r[0] == '0) begin
              npc_nxt = PA'(arg_r);
            end
          end
          fpvm_pkg::OP_ENTER: begin
            chk_b = addr_chk(n_enter, SWL);
            if (chk_b != fpvm_pkg::ST_RUN) begin
              err_nxt = chk_b;
            end else begin
              sp_nxt = SW'(n_enter);
            end
          end
          fpvm_pkg::OP_LEAVE: begin
            chk_b = addr_chk(n_leave, SWL);
            if (chk_b != fpvm_pkg::ST_RUN) begin
              err_nxt = chk_b;
            end else begin
              sp_nxt    = SW'(n_leave);
              pq0_nxt   = pv_r[0];
              pleft_nxt = 2'd1;
              state_nxt = S_PUSH;
            end
          end
          fpvm_pkg::OP_RETURN: begin
            chk_b = addr_chk(nb34, SWL);
            if (chk_b != fpvm_pkg::ST_RUN) begin
              err_nxt = chk_b;
            end else begin
              fb_nxt = SW'(nb34);
              chk_b  = addr_chk(n_leave, SWL);
              if (chk_b != fpvm_pkg::ST_RUN) begin
                err_nxt = chk_b;
              end else begin
                sp_nxt = SW'(n_leave);
                if (pv_r[1] == fpvm_pkg::RET_MARK) begin
                  status_nxt = fpvm_pkg::ST_RET;
                  value_nxt  = pv_r[0];
                end else begin
                  npc_nxt   = PA'(pv_r[1]);
                  pq0_nxt   = pv_r[0];
                  pleft_nxt = 2'd1;
                  state_nxt = S_PUSH;
                end
              end
            end
          end
          fpvm_pkg::OP_CALL: begin
            pq0_nxt   = 32'(fb_r);
            pq1_nxt   = 32'(npc_r);
            npc_nxt   = PA'(arg_r);
            pleft_nxt = 2'd2;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_ENTRY: begin
            pq0_nxt   = 32'(fb_r);
            pq1_nxt   = fpvm_pkg::RET_MARK;
            npc_nxt   = PA'(arg_r);
            pleft_nxt = 2'd2;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_POP: begin
            state_nxt = S_DONE;
          end
          fpvm_pkg::OP_TEQ, fpvm_pkg::OP_TNEQ, fpvm_pkg::OP_TL, fpvm_pkg::OP_TG,
          fpvm_pkg::OP_TLEQ, fpvm_pkg::OP_TGEQ: begin
            pq0_nxt   = cmp_hit ? fpvm_pkg::ONE_FX : 32'h0;
            pleft_nxt = 2'd1;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_DUP: begin
            pq0_nxt   = pv_r[0];
            pq1_nxt   = pv_r[0];
            pleft_nxt = 2'd2;
            state_nxt = S_PUSH;
          end
          fpvm_pkg::OP_AINIT, fpvm_pkg::OP_AINIT_G: begin
            state_nxt = S_EXEC;
            if (ph_r == 2'd0) begin
              chk_b = addr_chk(bx, LIM);
              if (ysh < 0) begin
                err_nxt   = fpvm_pkg::ST_BND;
                state_nxt = S_DONE;
              end else if (chk_b != fpvm_pkg::ST_RUN) begin
                err_nxt   = chk_b;
                state_nxt = S_DONE;
              end else if (bx + 34'sd1 + ysx > LIM) begin
                err_nxt   = fpvm_pkg::ST_OVF;
                state_nxt = S_DONE;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = AW'(bx);
                mem_wdata = 32'(bx + 34'sd1);
                x_nxt     = bx + 34'sd1;
                cnt_nxt   = 16'(ysh);
                ph_nxt    = 2'd1;
              end
            end else if (ph_r == 2'd1) begin
              mem_we    = 1'b1;
              mem_addr  = AW'(x_r);
              mem_wdata = 32'(ysx);
              x_nxt     = x_r + 34'sd1;
              ph_nxt    = 2'd2;
            end else if (cnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              mem_we   = 1'b1;
              mem_addr = AW'(x_r);
              x_nxt    = x_r + 34'sd1;
              cnt_nxt  = cnt_r - 16'd1;
            end
          end
          fpvm_pkg::OP_RD_ARR, fpvm_pkg::OP_RD_GARR,
          fpvm_pkg::OP_WR_ARR, fpvm_pkg::OP_WR_GARR: begin
            case (ph_r)
              2'd0: begin
                x_nxt     = bx;
                state_nxt = S_RD;
              end
              2'd1: begin
                d_nxt     = rd_r;
                x_nxt     = 34'($signed(rd_r));
                state_nxt = S_RD;
              end
              2'd2: begin
                if (ysh < 0 || ysx >= 34'($signed(rd_r))) begin
                  err_nxt = fpvm_pkg::ST_BND;
                end else begin
                  x_nxt = elem;
                  if (is_wr_arr) begin
                    ph_nxt    = 2'd3;
                    state_nxt = S_EXEC;
                  end else begin
                    state_nxt = S_RD;
                  end
                end
              end
              default: begin
                if (!is_wr_arr) begin
                  pq0_nxt   = rd_r;
                  pleft_nxt = 2'd1;
                  state_nxt = S_PUSH;
                end else if (chk_a != fpvm_pkg::ST_RUN) begin
                  err_nxt = chk_a;
                end else begin
                  mem_we    = 1'b1;
                  mem_addr  = AW'(x_r);
                  mem_wdata = pv_r[0];
                end
              end
            endcase
          end
          default: begin
            err_nxt = fpvm_pkg::ST_UNK;
          end
        endcase
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      sp_nxt  = cfg_sat;
      fb_nxt  = cfg_sat;
      err_nxt = fpvm_pkg::ST_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      sp_r    <= '0;
      fb_r    <= '0;
      err_r   <= fpvm_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sp_r    <= sp_nxt;
      fb_r    <= fb_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r     <= ph_nxt;
    op_r     <= op_nxt;
    arg_r    <= arg_nxt;
    npc_r    <= npc_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
    pv_r     <= pv_nxt;
    pcnt_r   <= pcnt_nxt;
    pneed_r  <= pneed_nxt;
    pleft_r  <= pleft_nxt;
    pq0_r    <= pq0_nxt;
    pq1_r    <= pq1_nxt;
    x_r      <= x_nxt;
    d_r      <= d_nxt;
    rd_r     <= rd_nxt;
    cnt_r    <= cnt_nxt;
    prod_r   <= prod_nxt;
  end

  fpvm_mem #(
    .DEPTH (STACK_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fpvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .dvd   (pv_r[1]),
    .dvs   (pv_r[0]),
    .done  (div_done),
    .quo   (div_q)
  );

  assign busy        = (state_r != S_IDLE);
  assign out_strobe  = (state_r == S_DONE);
  assign out_next_pc = 16'({{(32 - PA){1'b0}}, npc_r});
  assign out_status  = (err_r != fpvm_pkg::ST_RUN) ? err_r : status_r;
  assign out_value   = (err_r != fpvm_pkg::ST_RUN) ? 32'h0 : value_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe longer than one cycle");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(STACK_WORDS) && fb_r <= SW'(STACK_WORDS))
    else $error("stack pointer or frame base out of range");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != fpvm_pkg::ST_RET |-> out_value == 32'h0)
    else $error("value nonzero without return");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !mem_we)
    else $error("store written while idle");

endmodule
